### design/jbbs_pkg.sv
// shared types and constants of the json block boundary scanner
`timescale 1ns / 1ps
package jbbs_pkg;

	localparam int COUNT_W = 16;
	localparam int DEPTH_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 9'sd255;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -9'sd1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	// one result item
	typedef struct packed {
		logic [COUNT_W-1:0] len;
		logic [COUNT_W-1:0] lead;
		logic               complete;
		logic               last;
	} result_t;

	// results produced by one accepted byte, r0 goes out first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

### design/jbbs_core.sv
// scanner state and per-byte next-state logic
`timescale 1ns / 1ps
module jbbs_core import jbbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output push_t      push
);

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic signed [DEPTH_W-1:0] depth;
		logic                      in_str;
		logic                      in_word;
		logic                      esc;
		logic                      tok;
		logic [COUNT_W-1:0]        bc;
		logic [COUNT_W-1:0]        lc;
	} scan_state_t;

	scan_state_t state_q;
	scan_state_t st;
	scan_state_t state_d;
	logic        done;
	logic        emit_a;
	logic        ws;
	logic        ew;
	logic        fin_ok;
	result_t     res_a;
	result_t     res_b;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
			c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v != COUNT_MAX) ? v + 1'b1 : v;
	endfunction

	function automatic logic signed [DEPTH_W-1:0] dep_up(input logic signed [DEPTH_W-1:0] d);
		return (d < DEPTH_MAX) ? d + 9'sd1 : d;
	endfunction

	function automatic logic signed [DEPTH_W-1:0] dep_dn(input logic signed [DEPTH_W-1:0] d);
		return (d > DEPTH_MIN) ? d - 9'sd1 : d;
	endfunction

	assign ws = is_ws(data_byte);
	assign ew = ws || data_byte == CH_LBRACK || data_byte == CH_RBRACK ||
		data_byte == CH_LBRACE || data_byte == CH_RBRACE || data_byte == CH_QUOTE;

	always_comb begin
		st = state_q;
		done = 1'b0;
		emit_a = 1'b0;
		res_a = '0;
		// a finished block swallows trailing whitespace, anything else closes it
		if (st.tok && st.depth <= 0) begin
			if (ws) begin
				st.bc = sat_inc(st.bc);
				done = 1'b1;
			end else begin
				emit_a = 1'b1;
				res_a.len = st.bc;
				res_a.lead = st.lc;
				res_a.complete = 1'b1;
				st = '0;
			end
		end
		if (!done && st.in_word) begin
			if (ew) begin
				// word ends, the same byte is looked at again
				st.in_word = 1'b0;
				st.depth = dep_dn(st.depth);
				if (st.tok && st.depth <= 0) begin
					if (ws) begin
						st.bc = sat_inc(st.bc);
						done = 1'b1;
					end else begin
						emit_a = 1'b1;
						res_a.len = st.bc;
						res_a.lead = st.lc;
						res_a.complete = 1'b1;
						st = '0;
					end
				end
			end else begin
				st.bc = sat_inc(st.bc);
				done = 1'b1;
			end
		end
		if (!done) begin
			st.bc = sat_inc(st.bc);
			if (st.esc) begin
				st.esc = 1'b0;
			end else if (ws) begin
				if (!st.tok) begin
					st.lc = sat_inc(st.lc);
				end
			end else if (st.in_str) begin
				if (data_byte == CH_BSLASH) begin
					st.esc = 1'b1;
				end else if (data_byte == CH_QUOTE) begin
					st.in_str = 1'b0;
					st.depth = dep_dn(st.depth);
				end
			end else begin
				st.tok = 1'b1;
				priority if (data_byte == CH_LBRACK || data_byte == CH_LBRACE) begin
					st.depth = dep_up(st.depth);
				end else if (data_byte == CH_RBRACK || data_byte == CH_RBRACE) begin
					st.depth = dep_dn(st.depth);
				end else if (data_byte == CH_QUOTE) begin
					st.in_str = 1'b1;
					st.depth = dep_up(st.depth);
				end else begin
					st.in_word = 1'b1;
					st.depth = dep_up(st.depth);
				end
			end
		end
		// end of data closes whatever is open
		fin_ok = !st.tok || st.depth <= 0 || (st.in_word && st.depth == 9'sd1);
		res_b.len = st.bc;
		res_b.lead = st.lc;
		res_b.complete = fin_ok;
		res_b.last = 1'b1;
		state_d = end_of_data ? '0 : st;

		push = '0;
		if (accept) begin
			unique case ({emit_a, end_of_data})
				2'b11: begin
					push.n = 2'd2;
					push.r0 = res_a;
					push.r1 = res_b;
				end
				2'b10: begin
					push.n = 2'd1;
					push.r0 = res_a;
					push.r0.last = 1'b1;
				end
				2'b01: begin
					push.n = 2'd1;
					push.r0 = res_b;
				end
				default: begin
					push.n = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth >= DEPTH_MIN)
		else $error("nesting depth below -1");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_data |=> state_q.bc == '0 && !state_q.tok && state_q.depth == '0)
		else $error("state not cleared after end of data");

	a_escape_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.esc |-> state_q.in_str && !state_q.in_word)
		else $error("escape pending outside a string");

endmodule

### design/jbbs_outq.sv
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
module jbbs_outq import jbbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_item
);

	result_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                pop;

	assign out_valid = cnt_q != '0;
	assign out_item = mem_q[rd_ptr_q];
	assign pop = out_valid && out_ready;
	// room for the worst case of two results
	assign space = cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QUEUE_AW + 1)'(push.n) - (QUEUE_AW + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_needs_space: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> $past(cnt_q) == cnt_q || cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2))
		else $error("push into a queue without room");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd0 && !pop |=> $stable(cnt_q))
		else $error("queue count moved without a transaction");

endmodule

### design/json_block_boundary_scanner.sv
// top level of the json block boundary scanner
//
// channel  dir  tdata                                    tuser       tlast
// s_*      in   [7:0] data_byte                          -           end_of_data
// m_*      out  [15:0] block_length, [31:16] lead spaces [0] complete last_of_run
//
// one byte per cycle; the byte updates the scan state in the cycle it is taken
// results leave one per cycle while m_tready is high, from a four-entry queue,
// so a byte that both closes a block and ends the data pushes two results
// s_tready drops while fewer than two queue slots are free
// arst_n clears the scan state and empties the queue
`timescale 1ns / 1ps
module json_block_boundary_scanner import jbbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] block_length, [31:16] leading_spaces
	output logic        m_tuser,  // [0] complete
	output logic        m_tlast
);

	push_t   push;
	result_t head;
	logic    space;

	assign s_tready = space;

	jbbs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_tvalid && space),
		.data_byte   (s_tdata),
		.end_of_data (s_tlast),
		.push        (push)
	);

	jbbs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (head)
	);

	assign m_tdata = {head.lead, head.len};
	assign m_tuser = head.complete;
	assign m_tlast = head.last;

endmodule

### verif/tb_json_block_boundary_scanner.sv
// testbench of the json block boundary scanner: framing predictor, stream drivers and checks
`timescale 1ns / 1ps
module tb_json_block_boundary_scanner;
	import jbbs_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 280;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PERCENT = 8;
	localparam int MAX_PRINTED = 40;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	// tracks block framing of the accepted byte stream and holds the blocks still to come out
	class block_tracker;
		logic signed [DEPTH_W-1:0] depth;
		bit in_str;
		bit in_word;
		bit esc;
		bit tok;
		logic [COUNT_W-1:0] nbytes;
		logic [COUNT_W-1:0] nlead;
		result_t pending_blocks[$];
		int errors;

		function new();
			errors = 0;
			clear_scan();
		endfunction

		static function bit is_space(logic [7:0] c);
			return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		endfunction

		static function bit word_end(logic [7:0] c);
			return is_space(c) || (c inside {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
				CH_QUOTE});
		endfunction

		function logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
			return (v == COUNT_MAX) ? v : v + 1'b1;
		endfunction

		function void clear_scan();
			depth = '0;
			in_str = 0;
			in_word = 0;
			esc = 0;
			tok = 0;
			nbytes = '0;
			nlead = '0;
		endfunction

		function void depth_up();
			if (depth < DEPTH_MAX)
				depth = depth + 9'sd1;
		endfunction

		function void depth_down();
			if (depth > DEPTH_MIN)
				depth = depth - 9'sd1;
		endfunction

		function void close_block(bit done);
			result_t r;
			r.len = nbytes;
			r.lead = nlead;
			r.complete = done;
			r.last = 1'b0;
			pending_blocks.push_back(r);
			clear_scan();
		endfunction

		function void take_byte(logic [7:0] c, bit eod);
			int n;
			bit done;
			n = 0;
			while (1) begin
				// trailing whitespace stays with a finished block, anything else closes it
				if (tok && depth <= 0) begin
					if (is_space(c)) begin
						nbytes = sat_inc(nbytes);
						break;
					end
					close_block(1'b1);
					n++;
				end
				if (in_word) begin
					if (word_end(c)) begin
						in_word = 0;
						depth_down();
						continue;
					end
					nbytes = sat_inc(nbytes);
					break;
				end
				nbytes = sat_inc(nbytes);
				if (esc) begin
					esc = 0;
					break;
				end
				if (is_space(c)) begin
					if (!tok)
						nlead = sat_inc(nlead);
					break;
				end
				if (in_str) begin
					if (c == CH_BSLASH) begin
						esc = 1;
					end else if (c == CH_QUOTE) begin
						in_str = 0;
						depth_down();
					end
					break;
				end
				tok = 1;
				if (c == CH_LBRACK || c == CH_LBRACE) begin
					depth_up();
				end else if (c == CH_RBRACK || c == CH_RBRACE) begin
					depth_down();
				end else if (c == CH_QUOTE) begin
					in_str = 1;
					depth_up();
				end else begin
					in_word = 1;
					depth_up();
				end
				break;
			end
			if (eod) begin
				// an open bare word at depth one counts as finished
				done = !tok || depth <= 0 || (in_word && depth == 1);
				close_block(done);
				n++;
			end
			if (n > 0)
				pending_blocks[pending_blocks.size()-1].last = 1'b1;
		endfunction

		task report_mismatch(string what, int got, int want);
			if (errors < MAX_PRINTED)
				$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_block(logic [31:0] tdata, logic tuser, logic tlast);
			result_t e;
			if (pending_blocks.size() == 0) begin
				report_mismatch("unexpected result, blocks waiting", 1, 0);
				return;
			end
			e = pending_blocks.pop_front();
			if (tdata[15:0] !== e.len)
				report_mismatch("block_length", tdata[15:0], e.len);
			if (tdata[31:16] !== e.lead)
				report_mismatch("leading_spaces", tdata[31:16], e.lead);
			if (tuser !== e.complete)
				report_mismatch("complete", tuser, e.complete);
			if (tlast !== e.last)
				report_mismatch("last_of_run", tlast, e.last);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // [15:0] block_length, [31:16] leading_spaces
	logic        m_tuser;  // [0] complete
	logic        m_tlast;

	block_tracker sb;
	bit calm = 0;
	int sent = 0;
	logic [7:0] text_q[$];

	json_block_boundary_scanner i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// input transaction first, so a result can never be seen ahead of its byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_block(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit eod);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eod;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// the whole text buffer goes out with end_of_data on its last byte
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 5))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_VT;
			3: return CH_FF;
			4: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic void add_spaces(int maxn);
		repeat ($urandom_range(0, maxn))
			text_q.push_back(pick_space());
	endfunction

	function automatic void add_string();
		logic [7:0] b;
		text_q.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 9))
				0: begin
					text_q.push_back(CH_BSLASH);
					text_q.push_back(8'($urandom_range(0, 255)));
				end
				1: begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_QUOTE || b == CH_BSLASH)
						b = "q";
					text_q.push_back(b);
				end
				default: text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
			endcase
		end
		text_q.push_back(CH_QUOTE);
	endfunction

	function automatic void add_word();
		string s;
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: s = "true";
			1: s = "null";
			2: begin
				s = "";
				if ($urandom_range(0, 1))
					text_q.push_back(CH_MINUS);
				repeat ($urandom_range(1, 5))
					text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
			end
			default: begin
				// any byte that keeps a word open, high bytes and nul included
				s = "";
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					if (block_tracker::word_end(b))
						b = "w";
					text_q.push_back(b);
				end
			end
		endcase
		foreach (s[i])
			text_q.push_back(s[i]);
	endfunction

	function automatic void add_value(int lvl);
		int kind;
		int n;
		kind = (lvl >= 4) ? $urandom_range(2, 3) : $urandom_range(0, 3);
		case (kind)
			0: begin
				text_q.push_back(CH_LBRACE);
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0)
						text_q.push_back(CH_COMMA);
					add_spaces(2);
					add_string();
					add_spaces(1);
					text_q.push_back(CH_COLON);
					add_spaces(2);
					add_value(lvl + 1);
					add_spaces(1);
				end
				text_q.push_back(CH_RBRACE);
			end
			1: begin
				text_q.push_back(CH_LBRACK);
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0)
						text_q.push_back(CH_COMMA);
					add_spaces(2);
					add_value(lvl + 1);
					add_spaces(1);
				end
				text_q.push_back(CH_RBRACK);
			end
			2: add_string();
			default: add_word();
		endcase
	endfunction

	function automatic void add_noise();
		repeat ($urandom_range(1, 20)) begin
			case ($urandom_range(0, 9))
				0: text_q.push_back(CH_LBRACK);
				1: text_q.push_back(CH_RBRACK);
				2: text_q.push_back(CH_LBRACE);
				3: text_q.push_back(CH_RBRACE);
				4: text_q.push_back(CH_QUOTE);
				5: text_q.push_back(CH_BSLASH);
				6: text_q.push_back(pick_space());
				default: text_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic directed_part();
		// empty object
		text_q = '{CH_LBRACE, CH_RBRACE};
		send_text();
		// whitespace only
		text_q = '{CH_SPACE, CH_SPACE};
		send_text();
		// last byte closes one block and ends the next
		text_q = '{"1", CH_SPACE, "2"};
		send_text();
		// escape still open at the end
		text_q = '{CH_QUOTE, "a", CH_BSLASH};
		send_text();
		// word with nul and top byte, open at depth one
		text_q = '{"a", CH_NUL, 8'hFF};
		send_text();
		// close below zero
		text_q = '{CH_RBRACK};
		send_text();
		// unfinished array
		text_q = '{CH_LBRACK, CH_TAB};
		send_text();
		// escaped quote skipped, trailing vertical tab, form feed, carriage return and line feed
		text_q = '{CH_QUOTE, CH_BSLASH, CH_QUOTE, "x", CH_QUOTE, CH_VT, CH_FF, CH_CR, CH_LF};
		send_text();
	endtask

	task automatic long_part();
		// depth saturates, then unwinds past zero
		repeat (258)
			text_q.push_back(CH_LBRACK);
		repeat (260)
			text_q.push_back(CH_RBRACK);
		text_q.push_back(CH_SPACE);
		text_q.push_back("x");
		send_text();
	endtask

	task automatic random_part();
		int mode;
		int start;
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			calm = (sent - start > 100) && (sent - start < 200);
			mode = $urandom_range(0, 99);
			if (mode < 8) begin
				add_spaces(4);
			end else if (mode < 85) begin
				repeat ($urandom_range(1, 4)) begin
					add_spaces(3);
					add_value(0);
				end
				add_spaces(3);
				// cut off mid block
				if (mode >= 70 && text_q.size() > 1)
					repeat ($urandom_range(1, text_q.size() - 1))
						void'(text_q.pop_back());
			end else begin
				add_noise();
			end
			if (text_q.size() == 0)
				text_q.push_back(CH_SPACE);
			send_text();
		end
		calm = 0;
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_part();
		long_part();
		random_part();
		s_tvalid <= 1'b0;
		while (sb.pending_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_blocks.size() != 0)
			sb.report_mismatch("blocks left over", 0, sb.pending_blocks.size());
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
